FILE: rtl/ffha_pkg.sv
// ============================================================================
// ffha_pkg - shared types and constants for the first-fit hole allocator
// Command and status codes, fixed port field widths, parameter defaults.
// ============================================================================
package ffha_pkg;

  // Fixed widths of the port fields
  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int PID_W    = 8;
  localparam int STATUS_W = 2;

  // Parameter defaults
  localparam int MAX_HOLES_DEF = 16;
  localparam int ADDR_BITS_DEF = 16;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Outcome of checking one hole against a request
  typedef struct packed {
    logic fits;
    logic exact;
  } fit_flags_t;

endpackage

FILE: rtl/first_fit_hole_allocator_core.sv
// ============================================================================
// first_fit_hole_allocator_core - first-fit free hole table
// Ordered hole table in one synchronous RAM; add appends at the tail,
// allocate scans from the head and cuts or removes the first fitting hole.
// ============================================================================
//
//  channel   ports                                      handshake
//  --------  -----------------------------------------  ----------------------
//  input     in_command in_hole_start in_hole_end        start && !busy
//            in_process_id in_request_size
//  result    out_status out_granted_start                out_valid, one cycle
//            out_granted_end out_granted_owner
//
//  Add, or allocate on an empty table: result on the next cycle, busy stays low.
//  Allocate: the read of the first hole is issued on accept, then the scan
//  steps through the holes from the head, then on an exact fit every later
//  hole is moved up one place; scan and shift together cover at most the
//  hole count, and both go through the single RAM port.
//  Reset empties the table (count to zero); no clearing pass.
//  The receiver cannot stall: each result is a one-cycle out_valid pulse.
//
module first_fit_hole_allocator_core #(
  parameter int MAX_HOLES = ffha_pkg::MAX_HOLES_DEF,
  parameter int ADDR_BITS = ffha_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_hole_start,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_hole_end,
  input  logic [ffha_pkg::PID_W-1:0]    in_process_id,
  input  logic [ffha_pkg::SIZE_W-1:0]   in_request_size,
  output logic                          out_valid,
  output logic [ffha_pkg::STATUS_W-1:0] out_status,
  output logic [ffha_pkg::ADDR_W-1:0]   out_granted_start,
  output logic [ffha_pkg::ADDR_W-1:0]   out_granted_end,
  output logic [ffha_pkg::PID_W-1:0]    out_granted_owner
);
  import ffha_pkg::*;

  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int RW = (ADDR_BITS > ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int DW = 2 * ADDR_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  // hole table, entry = {start, end}
  logic [DW-1:0] mem [MAX_HOLES];
  logic [DW-1:0] rd_data_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0]   gstart_r, gstart_nxt;
  logic [ADDR_W-1:0]   gend_r, gend_nxt;
  logic [PID_W-1:0]    owner_r, owner_nxt;

  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_p2;
  logic          accept;

  logic [RW-1:0]        hs_ext;
  logic [RW-1:0]        he_ext;
  logic [ADDR_BITS-1:0] rd_start;
  logic [ADDR_BITS-1:0] rd_end;
  fit_flags_t           fit;
  logic [ADDR_BITS-1:0] cut_start;
  logic [ADDR_W-1:0]    fit_gstart;
  logic [ADDR_W-1:0]    fit_gend;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign idx_p1   = idx_r + CW'(1);
  assign idx_p2   = idx_r + CW'(2);
  assign hs_ext   = RW'(in_hole_start);
  assign he_ext   = RW'(in_hole_end);
  assign rd_start = rd_data_r[DW-1:ADDR_BITS];
  assign rd_end   = rd_data_r[ADDR_BITS-1:0];

  ffha_fit_check #(
    .ADDR_BITS (ADDR_BITS)
  ) u_fit (
    .hole_start  (rd_start),
    .hole_end    (rd_end),
    .req_size    (size_r),
    .flags       (fit),
    .cut_start   (cut_start),
    .grant_start (fit_gstart),
    .grant_end   (fit_gend)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    size_nxt      = size_r;
    pid_nxt       = pid_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    gstart_nxt    = gstart_r;
    gend_nxt      = gend_r;
    owner_nxt     = owner_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IW-1:0];
    mem_wdata     = rd_data_r;
    mem_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        mem_raddr = '0;
        if (accept) begin
          gstart_nxt = '0;
          gend_nxt   = '0;
          owner_nxt  = '0;
          if (in_command == CMD_ADD) begin
            out_valid_nxt = 1'b1;
            if (count_r == CW'(MAX_HOLES)) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_ADDED;
              mem_we     = 1'b1;
              mem_waddr  = count_r[IW-1:0];
              mem_wdata  = {hs_ext[ADDR_BITS-1:0], he_ext[ADDR_BITS-1:0]};
              count_nxt  = count_r + CW'(1);
            end
          end else begin
            size_nxt = in_request_size;
            pid_nxt  = in_process_id;
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_NOFIT;
            end else begin
              // read of entry 0 issued this cycle
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // rd_data_r holds entry idx_r; prefetch the next one
        mem_raddr = idx_p1[IW-1:0];
        if (fit.fits) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_ALLOC;
          gstart_nxt    = fit_gstart;
          gend_nxt      = fit_gend;
          owner_nxt     = pid_r;
          if (fit.exact) begin
            if (idx_p1 == count_r) begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SHIFT;
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {cut_start, rd_end};
            state_nxt = S_IDLE;
          end
        end else if (idx_p1 == count_r) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_NOFIT;
          gstart_nxt    = '0;
          gend_nxt      = '0;
          owner_nxt     = '0;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_p1;
        end
      end

      S_SHIFT: begin
        // rd_data_r holds entry idx_r+1; move it up into idx_r
        mem_raddr = idx_p2[IW-1:0];
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        if (idx_p2 == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_p1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r   <= size_nxt;
    pid_r    <= pid_nxt;
    status_r <= status_nxt;
    gstart_r <= gstart_nxt;
    gend_r   <= gend_nxt;
    owner_r  <= owner_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_start = gstart_r;
  assign out_granted_end   = gend_r;
  assign out_granted_owner = owner_r;

  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_HOLES))
    else $error("hole count above table depth");

  a_add_result : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_ADD)) |=> out_valid_r)
    else $error("add transaction without result next cycle");

  a_scan_index : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r < count_r))
    else $error("scan index past last hole");

  a_shift_index : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_p2 <= count_r))
    else $error("shift reads past last hole");

  a_alloc_from_scan : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_ALLOC)) |-> $past(state_r == S_SCAN))
    else $error("grant not produced by scan");

endmodule

FILE: rtl/ffha_fit_check.sv
// ============================================================================
// ffha_fit_check - hole versus request comparison
// Decides whether a hole holds the request, whether it is an exact fit,
// and forms the cut start and the grant addresses.
// ============================================================================
module ffha_fit_check #(
  parameter int ADDR_BITS = ffha_pkg::ADDR_BITS_DEF
) (
  input  logic [ADDR_BITS-1:0]        hole_start,
  input  logic [ADDR_BITS-1:0]        hole_end,
  input  logic [ffha_pkg::SIZE_W-1:0] req_size,
  output ffha_pkg::fit_flags_t        flags,
  output logic [ADDR_BITS-1:0]        cut_start,
  output logic [ffha_pkg::ADDR_W-1:0] grant_start,
  output logic [ffha_pkg::ADDR_W-1:0] grant_end
);
  import ffha_pkg::*;

  localparam int RW = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;

  logic [RW-1:0] s_ext;
  logic [RW-1:0] e_ext;
  logic [RW-1:0] sz_ext;
  logic [RW-1:0] room;
  logic [RW-1:0] sum;

  always_comb begin
    s_ext  = RW'(hole_start);
    e_ext  = RW'(hole_end);
    sz_ext = RW'(req_size);
    room   = e_ext - s_ext;
    // inverted hole never fits
    flags.fits  = (e_ext >= s_ext) && (room >= sz_ext);
    flags.exact = flags.fits && (room == sz_ext);
    // for a fitting hole start + size stays at or below the hole end, so no wrap
    sum         = s_ext + sz_ext;
    cut_start   = sum[ADDR_BITS-1:0];
    grant_start = s_ext[ADDR_W-1:0];
    grant_end   = sum[ADDR_W-1:0];
  end

endmodule
